// ===== hw/rtl/fsa_pkg.sv =====
// Shared types, widths and constants of the five-point stencil block.
// Used by every module of the block but fsa_ram; depends on nothing.

package fsa_pkg;

  // Grid and sample geometry.
  localparam int unsigned MAX_LOG2    = 8;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned GRID_MAX    = (1 << MAX_LOG2) + 2;
  localparam int unsigned POS_BITS    = $clog2(GRID_MAX);
  localparam int unsigned CFG_BITS    = 4;

  // Five samples summed, plus the rounding term, never overflow this width.
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + 3;

  // Reciprocal of five: floor(x * RECIP5 / 2^RECIP_SHIFT) == x / 5 for x < 2^SUM_BITS.
  localparam int unsigned RECIP_SHIFT = SUM_BITS + 2;
  localparam logic [RECIP_SHIFT-1:0] RECIP5 =
    RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);
  localparam int unsigned PROD_BITS   = SUM_BITS + RECIP_SHIFT;

  // Line buffer word: the row before last and the previous row at one column.
  localparam int unsigned LINE_BITS   = 2 * SAMPLE_BITS;

  // Queue between the front and the back part.
  localparam int unsigned QPTR_BITS   = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QPTR_BITS;
  localparam int unsigned QCNT_BITS   = QPTR_BITS + 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] prev2;
    logic [SAMPLE_BITS-1:0] prev;
  } line_word_t;

  // One classified input beat, with everything the back part needs.
  typedef struct packed {
    logic [SUM_BITS-1:0]    sum;
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] sample;
    logic [POS_BITS-1:0]    row;
    logic [POS_BITS-1:0]    col;
    logic                   emit_prev;
    logic                   prev_border;
    logic                   emit_self;
    logic                   self_done;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] temp;
    logic [POS_BITS-1:0]    row;
    logic [POS_BITS-1:0]    col;
    logic                   border;
    logic                   last;
    logic                   done;
  } result_t;

endpackage

// ===== hw/rtl/five_point_stencil_average.sv =====
// Top level of the five-point stencil (one Jacobi step) block.
// Uses fsa_pkg, fsa_front, fsa_queue and fsa_back.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          temp_in_i, frame_start_i
//   result    out        empty / pop          temp_out_o, out_row_o, out_col_o,
//                                             border_point_o, last_of_run_o,
//                                             frame_done_o
//   config    in         cfg_valid/cfg_ready  inner_size_log2_i
//
// One input beat per cycle is sustained while full stays low; an accepted beat
// passes the second stage, the queue and the output register to the result ports.
// Beats of the last grid row cause two results each, so the single result port
// holds back the input during that row.
// Reset clears the position, the configuration (inner side 2^8) and the queue;
// the line buffers need no clearing pass. A stalled result port fills the
// four-entry queue, and full rises before it overflows.

module five_point_stencil_average (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [fsa_pkg::SAMPLE_BITS-1:0] temp_in_i,
  input  logic                            frame_start_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [fsa_pkg::SAMPLE_BITS-1:0] temp_out_o,
  output logic [fsa_pkg::POS_BITS-1:0]    out_row_o,
  output logic [fsa_pkg::POS_BITS-1:0]    out_col_o,
  output logic                            border_point_o,
  output logic                            last_of_run_o,
  output logic                            frame_done_o,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsa_pkg::CFG_BITS-1:0]    inner_size_log2_i
);

  logic                          accept;
  logic                          q_push, q_pop, q_head_valid;
  fsa_pkg::item_t                q_item, q_head;
  logic [fsa_pkg::QCNT_BITS-1:0] q_count;
  logic [fsa_pkg::QCNT_BITS:0]   occupancy;
  fsa_pkg::result_t              result;

  // Accept only when the queue has room for every beat still in flight.
  assign occupancy = {1'b0, q_count} + {{fsa_pkg::QCNT_BITS{1'b0}}, q_push};
  assign full      = (occupancy >= (fsa_pkg::QCNT_BITS + 1)'(fsa_pkg::QUEUE_DEPTH));
  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  fsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_fire_i   (cfg_valid && cfg_ready),
    .cfg_data_i   (inner_size_log2_i),
    .accept_i     (accept),
    .temp_i       (temp_in_i),
    .frame_start_i(frame_start_i),
    .push_o       (q_push),
    .item_o       (q_item)
  );

  fsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .item_i      (q_item),
    .pop_i       (q_pop),
    .head_valid_o(q_head_valid),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  fsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_head_valid),
    .head_i      (q_head),
    .head_pop_o  (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result)
  );

  assign temp_out_o     = result.temp;
  assign out_row_o      = result.row;
  assign out_col_o      = result.col;
  assign border_point_o = result.border;
  assign last_of_run_o  = result.last;
  assign frame_done_o   = result.done;

endmodule

// ===== hw/rtl/fsa_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// Standalone; depends on nothing.

module fsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 258,
  localparam int unsigned ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_a_i,
  input  logic [ADDR_BITS-1:0] raddr_b_i,
  output logic [WIDTH-1:0]     rdata_a_o,
  output logic [WIDTH-1:0]     rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/fsa_front.sv =====
// Front part: configuration register, grid position, classification of each
// input beat, the line buffers and the five-point sum. Uses fsa_pkg and fsa_ram.

module fsa_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_fire_i,
  input  logic [fsa_pkg::CFG_BITS-1:0]    cfg_data_i,
  input  logic                            accept_i,
  input  logic [fsa_pkg::SAMPLE_BITS-1:0] temp_i,
  input  logic                            frame_start_i,
  output logic                            push_o,
  output fsa_pkg::item_t                  item_o
);

  logic [fsa_pkg::CFG_BITS-1:0]    log2_q;
  logic [fsa_pkg::POS_BITS-1:0]    row_q, row_d;
  logic [fsa_pkg::POS_BITS-1:0]    col_q, col_d;
  logic [fsa_pkg::POS_BITS-1:0]    side_last;
  logic [fsa_pkg::POS_BITS-1:0]    cur_row, cur_col, east_col;
  logic                            restart;

  // Second stage: the beat whose line buffer read is coming back.
  logic                            b_valid_q;
  logic [fsa_pkg::SAMPLE_BITS-1:0] b_sample_q;
  logic [fsa_pkg::POS_BITS-1:0]    b_row_q, b_col_q;
  logic                            b_emit_prev_q, b_prev_border_q;
  logic                            b_emit_self_q, b_self_done_q;
  logic [fsa_pkg::SAMPLE_BITS-1:0] west_q;

  logic [fsa_pkg::LINE_BITS-1:0]   rdata_a, rdata_b;
  fsa_pkg::line_word_t             word_a, word_b, word_w;
  logic [fsa_pkg::SUM_BITS-1:0]    sum;

  // Position of the incoming beat; a frame start or a stale position restarts.
  always_comb begin
    side_last = (fsa_pkg::POS_BITS'(1) << log2_q) + fsa_pkg::POS_BITS'(1);
    restart   = frame_start_i || (row_q > side_last) || (col_q > side_last);
    cur_row   = restart ? '0 : row_q;
    cur_col   = restart ? '0 : col_q;
    east_col  = (cur_col == fsa_pkg::POS_BITS'(fsa_pkg::GRID_MAX - 1)) ?
                cur_col : cur_col + fsa_pkg::POS_BITS'(1);
    if (cur_col == side_last) begin
      col_d = '0;
      row_d = (cur_row == side_last) ? '0 : cur_row + fsa_pkg::POS_BITS'(1);
    end else begin
      col_d = cur_col + fsa_pkg::POS_BITS'(1);
      row_d = cur_row;
    end
  end

  // Configuration and position registers; a register write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= fsa_pkg::CFG_BITS'(fsa_pkg::MAX_LOG2);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_fire_i) begin
      log2_q <= (cfg_data_i > fsa_pkg::CFG_BITS'(fsa_pkg::MAX_LOG2)) ?
                fsa_pkg::CFG_BITS'(fsa_pkg::MAX_LOG2) : cfg_data_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (accept_i) begin
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  // Classify the beat on its way into the second stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      b_sample_q      <= temp_i;
      b_row_q         <= cur_row;
      b_col_q         <= cur_col;
      b_emit_prev_q   <= (cur_row != '0);
      b_prev_border_q <= (cur_row == fsa_pkg::POS_BITS'(1)) || (cur_col == '0) ||
                         (cur_col == side_last);
      b_emit_self_q   <= (cur_row == side_last);
      b_self_done_q   <= (cur_col == side_last);
    end
  end

  // Line buffers: each entry holds the two rows above the current one.
  fsa_ram #(
    .WIDTH(fsa_pkg::LINE_BITS),
    .DEPTH(fsa_pkg::GRID_MAX)
  ) u_line (
    .clk_i    (clk_i),
    .we_i     (b_valid_q),
    .waddr_i  (b_col_q),
    .wdata_i  (word_w),
    .re_i     (accept_i),
    .raddr_a_i(cur_col),
    .raddr_b_i(east_col),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // Neighbors and their sum; the rows shift down one line at this column.
  always_comb begin
    word_a       = fsa_pkg::line_word_t'(rdata_a);
    word_b       = fsa_pkg::line_word_t'(rdata_b);
    word_w.prev2 = word_a.prev;
    word_w.prev  = b_sample_q;
    sum = fsa_pkg::SUM_BITS'(word_a.prev2) + fsa_pkg::SUM_BITS'(b_sample_q) +
          fsa_pkg::SUM_BITS'(west_q) + fsa_pkg::SUM_BITS'(word_a.prev) +
          fsa_pkg::SUM_BITS'(word_b.prev);
  end

  // The west neighbor is the center of the beat before.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      west_q <= '0;
    end else if (b_valid_q) begin
      west_q <= word_a.prev;
    end
  end

  // Hand the beat to the queue when it causes any result.
  always_comb begin
    push_o             = b_valid_q && (b_emit_prev_q || b_emit_self_q);
    item_o.sum         = sum;
    item_o.center      = word_a.prev;
    item_o.sample      = b_sample_q;
    item_o.row         = b_row_q;
    item_o.col         = b_col_q;
    item_o.emit_prev   = b_emit_prev_q;
    item_o.prev_border = b_prev_border_q;
    item_o.emit_self   = b_emit_self_q;
    item_o.self_done   = b_self_done_q;
  end

  // The second stage holds exactly the beat accepted in the previous cycle.
  a_stage_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q == $past(accept_i))
    else $error("second stage does not match the accepted beat");

  // The position counters never leave the current grid.
  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= side_last) && (col_q <= side_last))
    else $error("grid position out of range");

endmodule

// ===== hw/rtl/fsa_queue.sv =====
// Short queue of classified beats between the front and the back part.
// Uses fsa_pkg.

module fsa_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  fsa_pkg::item_t                item_i,
  input  logic                          pop_i,
  output logic                          head_valid_o,
  output fsa_pkg::item_t                head_o,
  output logic [fsa_pkg::QCNT_BITS-1:0] count_o
);

  fsa_pkg::item_t                 slots_q [fsa_pkg::QUEUE_DEPTH];
  logic [fsa_pkg::QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [fsa_pkg::QCNT_BITS-1:0]  count_q;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + fsa_pkg::QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + fsa_pkg::QPTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + fsa_pkg::QCNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - fsa_pkg::QCNT_BITS'(1);
      end
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign count_o      = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && (count_q == fsa_pkg::QCNT_BITS'(fsa_pkg::QUEUE_DEPTH))))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && (count_q == '0)))
    else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/fsa_back.sv =====
// Back part: the divide by five, expansion of a beat into one or two results,
// and the output register. Uses fsa_pkg.

module fsa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  fsa_pkg::item_t   head_i,
  output logic             head_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output fsa_pkg::result_t result_o
);

  logic                            out_valid_q, out_valid_d;
  logic                            phase_q, phase_d;
  fsa_pkg::result_t                result_q;
  fsa_pkg::result_t                prev_res, self_res, sel_res;
  logic                            can_load, take, first;
  logic [fsa_pkg::SUM_BITS-1:0]    rounded;
  logic [fsa_pkg::PROD_BITS-1:0]   prod;
  logic [fsa_pkg::SAMPLE_BITS-1:0] mean;

  // Rounded mean: (sum + 2) / 5 by the reciprocal multiply.
  always_comb begin
    rounded = head_i.sum + fsa_pkg::SUM_BITS'(2);
    prod    = fsa_pkg::PROD_BITS'(rounded) * fsa_pkg::PROD_BITS'(fsa_pkg::RECIP5);
    mean    = prod[fsa_pkg::RECIP_SHIFT +: fsa_pkg::SAMPLE_BITS];
  end

  // The two results a beat can cause: the point one row up, and itself.
  always_comb begin
    prev_res.temp   = head_i.prev_border ? head_i.center : mean;
    prev_res.row    = head_i.row - fsa_pkg::POS_BITS'(1);
    prev_res.col    = head_i.col;
    prev_res.border = head_i.prev_border;
    prev_res.last   = !head_i.emit_self;
    prev_res.done   = 1'b0;

    self_res.temp   = head_i.sample;
    self_res.row    = head_i.row;
    self_res.col    = head_i.col;
    self_res.border = 1'b1;
    self_res.last   = 1'b1;
    self_res.done   = head_i.self_done;
  end

  // Load the output register whenever it is free or being taken.
  always_comb begin
    can_load    = !out_valid_q || pop_i;
    take        = can_load && head_valid_i;
    first       = !phase_q && head_i.emit_prev;
    sel_res     = first ? prev_res : self_res;
    head_pop_o  = take && !(first && head_i.emit_self);
    out_valid_d = can_load ? head_valid_i : out_valid_q;
    phase_d     = take ? (first && head_i.emit_self) : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= sel_res;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = result_q;

  // The second result of a beat is only pending behind a shown first one.
  a_phase_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (out_valid_q && head_valid_i))
    else $error("second result pending without a shown first result");

endmodule
